@@ src/wheel_angle_calibrate_check_top_defines.svh @@
// Assertion macros shared by the wheel angle checker modules.
// Each expects clk and rst_n in scope.
`ifndef WHEEL_ANGLE_CALIBRATE_CHECK_TOP_DEFINES_SVH
`define WHEEL_ANGLE_CALIBRATE_CHECK_TOP_DEFINES_SVH

// Same-cycle implication
`define WAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wac_pkg.sv @@
package wac_pkg;

  // Field widths
  localparam int RAW_W  = 16;
  localparam int TS_W   = 64;
  localparam int CDEG_W = 16;
  localparam int MV_W   = 13;
  localparam int ABS_W  = 15;
  localparam int CODE_W = 3;

  // Arithmetic widths
  localparam int DIFF_W    = RAW_W + 1;
  localparam int PROD_W    = 2 * RAW_W;
  localparam int ANG_W     = PROD_W + 2;
  localparam int MVP_W     = RAW_W + MV_W;
  localparam int DIV_CYC   = PROD_W / 2;
  localparam int CNT_W     = $clog2(DIV_CYC);

  // Port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 5;

  localparam logic [RAW_W:0] RAW_FULL = 17'd65535;

  typedef enum logic [CODE_W-1:0] {
    FAULT_NONE        = 3'd0,
    FAULT_NO_ADC      = 3'd1,
    FAULT_SPAN_ZERO   = 3'd2,
    FAULT_RAW_RANGE   = 3'd3,
    FAULT_IMPLAUSIBLE = 3'd4
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_LOW_RAW     = 3'd0,
    REG_CAL_HIGH_RAW    = 3'd1,
    REG_CAL_LOW_CDEG    = 3'd2,
    REG_CAL_HIGH_CDEG   = 3'd3,
    REG_VREF_MV         = 3'd4,
    REG_ABS_LIMIT_CDEG  = 3'd5,
    REG_JUMP_LIMIT_CDEG = 3'd6,
    REG_ADC_PRESENT     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ANGLE,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic div_step;
    logic angle_en;
    logic check_en;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic out_valid;
  } sts_t;

endpackage

@@ src/wac_div.sv @@
`include "wheel_angle_calibrate_check_top_defines.svh"

module wac_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        step,
  input  logic [wac_pkg::PROD_W-1:0]  dividend,
  input  logic [wac_pkg::RAW_W-1:0]   divisor,
  output logic [wac_pkg::PROD_W-1:0]  quotient
);
  import wac_pkg::*;

  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [RAW_W-1:0]  rem_r, rem_nxt;
  logic [RAW_W:0]    r1, r1s, r2, r2s;
  logic              ge1, ge2;

  // Two restoring steps per cycle; quotient bits shift in as dividend shifts out
  always_comb begin
    r1      = {rem_r, quo_r[PROD_W-1]};
    ge1     = r1 >= {1'b0, divisor};
    r1s     = ge1 ? r1 - {1'b0, divisor} : r1;
    r2      = {r1s[RAW_W-1:0], quo_r[PROD_W-2]};
    ge2     = r2 >= {1'b0, divisor};
    r2s     = ge2 ? r2 - {1'b0, divisor} : r2;
    rem_nxt = r2s[RAW_W-1:0];
    quo_nxt = {quo_r[PROD_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

  // Remainder stays below a nonzero divisor
  `WAC_ASSERT_NEXT(a_rem_below, step && !load && divisor != '0, rem_r < divisor, "remainder not below divisor")

endmodule

@@ src/wac_ctrl.sv @@
`include "wheel_angle_calibrate_check_top_defines.svh"

module wac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wac_pkg::sts_t sts,
  output wac_pkg::cmd_t cmd
);
  import wac_pkg::*;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYC - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencer: take item, multiply, divide, form angle, check, hand over
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.angle_en = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check_en = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `WAC_ASSERT_NEXT(a_accept_mul, in_tvalid && in_tready, state_r == ST_MUL, "accepted item did not start")
  `WAC_ASSERT_NEXT(a_div_exit, state_r == ST_DIV && cnt_r == DIV_LAST, state_r == ST_ANGLE, "divide overran")
  `WAC_ASSERT_NEXT(a_load_valid, cmd.out_load, sts.out_valid, "result not presented after load")

endmodule

@@ src/wac_dp.sv @@
`include "wheel_angle_calibrate_check_top_defines.svh"

module wac_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wac_pkg::cmd_t                     cmd,
  output wac_pkg::sts_t                     sts,
  input  logic [wac_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wac_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [wac_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wac_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wac_pkg::*;

  // Configuration registers
  logic [RAW_W-1:0]  cal_low_raw_r, cal_high_raw_r;
  logic [CDEG_W-1:0] cal_low_cdeg_r, cal_high_cdeg_r;
  logic [MV_W-1:0]   vref_mv_r;
  logic [ABS_W-1:0]  abs_limit_r;
  logic [CDEG_W-1:0] jump_limit_r;
  logic              adc_present_r;

  // Running state
  logic [CDEG_W-1:0] last_good_r;
  logic              have_good_r;
  logic [TS_W-1:0]   last_time_r;

  // Item working registers
  logic [RAW_W-1:0]  raw_r;
  logic [TS_W-1:0]   ts_r;
  logic [RAW_W-1:0]  dmag_r, smag_r, span_r;
  logic              neg_r;
  logic [MVP_W-1:0]  mvp_r;
  logic [ANG_W-1:0]  angle_r;
  logic [MV_W-1:0]   mv_r;
  logic              abs_bad_r, jump_bad_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic [RAW_W-1:0]  in_raw;
  logic [DIFF_W-1:0] diff, dspan, dabs, sabs;
  logic [PROD_W-1:0] prod, quotient;
  logic [ANG_W-1:0]  qext, angle_nxt, amag;
  logic [DIFF_W-1:0] jump, jmag;
  logic [RAW_W:0]    mv_sum;
  logic [MV_W-1:0]   mv_hi, mv_nxt;

  logic              res_valid, res_fresh;
  fault_t            res_code;
  logic [CDEG_W-1:0] res_angle;
  logic [RAW_W-1:0]  res_raw;
  logic [MV_W-1:0]   res_mv;
  logic [TS_W-1:0]   res_time;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_raw_r   <= 16'd0;
      cal_high_raw_r  <= 16'd65535;
      cal_low_cdeg_r  <= 16'hF060;
      cal_high_cdeg_r <= 16'd4000;
      vref_mv_r       <= 13'd3300;
      abs_limit_r     <= 15'd4000;
      jump_limit_r    <= 16'd500;
      adc_present_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CAL_LOW_RAW:     cal_low_raw_r   <= cfg_data;
        REG_CAL_HIGH_RAW:    cal_high_raw_r  <= cfg_data;
        REG_CAL_LOW_CDEG:    cal_low_cdeg_r  <= cfg_data;
        REG_CAL_HIGH_CDEG:   cal_high_cdeg_r <= cfg_data;
        REG_VREF_MV:         vref_mv_r       <= cfg_data[MV_W-1:0];
        REG_ABS_LIMIT_CDEG:  abs_limit_r     <= cfg_data[ABS_W-1:0];
        REG_JUMP_LIMIT_CDEG: jump_limit_r    <= cfg_data;
        REG_ADC_PRESENT:     adc_present_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input stage: offsets and their magnitudes
  assign in_raw = in_tdata[TS_W +: RAW_W];
  assign diff   = {1'b0, in_raw} - {1'b0, cal_low_raw_r};
  assign dspan  = {cal_high_cdeg_r[CDEG_W-1], cal_high_cdeg_r}
                - {cal_low_cdeg_r[CDEG_W-1], cal_low_cdeg_r};
  assign dabs   = diff[DIFF_W-1] ? -diff : diff;
  assign sabs   = dspan[DIFF_W-1] ? -dspan : dspan;

  // Unsigned magnitude product feeds the divider directly
  assign prod = dmag_r * smag_r;

  wac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.mul_en),
    .step     (cmd.div_step),
    .dividend (prod),
    .divisor  (span_r),
    .quotient (quotient)
  );

  // Signed angle from truncated quotient
  assign qext      = {2'b00, quotient};
  assign angle_nxt = {{(ANG_W-CDEG_W){cal_low_cdeg_r[CDEG_W-1]}}, cal_low_cdeg_r}
                   + (neg_r ? -qext : qext);

  // Plausibility terms
  assign amag = angle_r[ANG_W-1] ? -angle_r : angle_r;
  assign jump = {angle_r[CDEG_W-1], angle_r[CDEG_W-1:0]}
              - {last_good_r[CDEG_W-1], last_good_r};
  assign jmag = jump[DIFF_W-1] ? -jump : jump;

  // raw*vref/65535: high part plus one correction
  assign mv_hi  = mvp_r[MVP_W-1:RAW_W];
  assign mv_sum = {1'b0, mvp_r[RAW_W-1:0]} + (RAW_W+1)'(mv_hi);
  assign mv_nxt = mv_hi + MV_W'(mv_sum >= RAW_FULL);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r  <= in_raw;
      ts_r   <= in_tdata[TS_W-1:0];
      span_r <= cal_high_raw_r - cal_low_raw_r;
      smag_r <= sabs[RAW_W-1:0];
      neg_r  <= diff[DIFF_W-1] ^ dspan[DIFF_W-1];
    end
    if (cmd.mul_en) mvp_r <= MVP_W'(raw_r) * MVP_W'(vref_mv_r);
    if (cmd.angle_en) angle_r <= angle_nxt;
    if (cmd.check_en) begin
      abs_bad_r  <= amag > ANG_W'(abs_limit_r);
      jump_bad_r <= (jump_limit_r != '0) && have_good_r
                 && (jmag > {1'b0, jump_limit_r});
      mv_r       <= mv_nxt;
    end
  end

  // dmag_r mirrors the diff magnitude for the product
  always_ff @(posedge clk) begin
    if (cmd.load_in) dmag_r <= dabs[RAW_W-1:0];
  end

  // Fault priority and result fields
  always_comb begin
    res_valid = 1'b0;
    res_fresh = 1'b1;
    res_code  = FAULT_NONE;
    res_angle = last_good_r;
    res_raw   = raw_r;
    res_mv    = mv_r;
    res_time  = ts_r;
    if (!adc_present_r) begin
      res_fresh = 1'b0;
      res_code  = FAULT_NO_ADC;
      res_raw   = '0;
      res_mv    = '0;
      res_time  = last_time_r;
    end else if (raw_r == '0 && cal_low_raw_r != '0) begin
      res_code = FAULT_RAW_RANGE;
    end else if (span_r == '0) begin
      res_code  = FAULT_SPAN_ZERO;
      res_angle = '0;
    end else if (abs_bad_r || jump_bad_r) begin
      res_code = FAULT_IMPLAUSIBLE;
    end else begin
      res_valid = 1'b1;
      res_angle = angle_r[CDEG_W-1:0];
    end
  end

  // Running state update when a result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r <= '0;
      have_good_r <= 1'b0;
      last_time_r <= '0;
    end else if (cmd.out_load) begin
      if (adc_present_r) last_time_r <= ts_r;
      if (res_valid) begin
        last_good_r <= res_angle;
        have_good_r <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'b000, res_time, res_mv, res_raw, res_angle};
      out_user_r <= {res_code, res_fresh, res_valid};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_user_r;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.out_valid = out_valid_r;

  `WAC_ASSERT_IMPL(a_valid_clean, out_valid_r && out_user_r[0], out_user_r[4:2] == FAULT_NONE && out_user_r[1], "valid angle with fault")
  `WAC_ASSERT_NEXT(a_good_kept, cmd.out_load && res_valid, have_good_r && last_good_r == $past(res_angle), "good angle not kept")

endmodule

@@ src/wheel_angle_calibrate_check_top.sv @@
// Wheel angle calibration and plausibility checker. Each input item (timestamp,
// raw 16-bit converter sample) yields one result item: angle in centidegrees by
// two-point linear calibration, fault code, raw echo, voltage in millivolts and
// sample time. An item is multiplied, divided, formed into an angle and checked
// before its result enters the output register and the next item is accepted;
// the divider forms the quotient two bits per cycle. The result waits
// in an output register, so a stalled output delays only the hand-over of the
// following item. Configuration writes are taken every cycle and must only be
// made while no item is in flight.
module wheel_angle_calibrate_check_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] sample_ts, [79:64] raw_sample
  input  logic [wac_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] angle_cdeg, [31:16] raw_echo, [44:32] voltage_mv, [108:45] sample_time_us
  output logic [wac_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] angle_valid, [1] fresh_flag, [4:2] fault_code
  output logic [wac_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wac_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

@@ bench/wheel_angle_checker.sv @@
// Watches the sample, result and register channels of the wheel angle block,
// keeps its own copy of the calibration registers and the held-angle state,
// and compares every result item with the reading it should carry.
module wheel_angle_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [63:0] sample_ts, [79:64] raw_sample
  input  logic [wac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] angle_cdeg, [31:16] raw_echo, [44:32] voltage_mv, [108:45] sample_time_us
  input  logic [wac_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] angle_valid, [1] fresh_flag, [4:2] fault_code
  input  logic [wac_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import wac_pkg::*;

  typedef struct {
    logic        valid;
    logic        fresh;
    fault_t      code;
    logic [15:0] angle;
    logic [15:0] raw;
    logic [12:0] mv;
    logic [63:0] ts;
  } reading_t;

  // Calibration registers
  logic [15:0]        low_raw, high_raw;
  logic signed [15:0] low_cdeg, high_cdeg;
  logic [12:0]        vref;
  logic [14:0]        abs_lim;
  logic [15:0]        jump_lim;
  logic               present;

  // Held state
  logic signed [15:0] last_good;
  logic               have_good;
  logic [63:0]        last_read;

  reading_t expected_readings[$];
  int       errs;

  // Expected reading for one sample; updates the held state as the block does
  function automatic reading_t predict_reading(input logic [63:0] ts, input logic [15:0] raw);
    reading_t   r;
    logic [15:0] span;
    longint      angle, mag, jump;
    r.valid = 1'b0;
    r.fresh = 1'b1;
    r.code  = FAULT_NONE;
    r.angle = last_good;
    r.raw   = raw;
    r.ts    = ts;
    r.mv    = 13'((64'(raw) * 64'(vref)) / 64'd65535);
    span    = high_raw - low_raw;
    if (!present) begin
      r.fresh = 1'b0;
      r.code  = FAULT_NO_ADC;
      r.raw   = '0;
      r.mv    = '0;
      r.ts    = last_read;
      return r;
    end
    last_read = ts;
    if (raw == 16'd0 && low_raw != 16'd0) begin
      r.code = FAULT_RAW_RANGE;
    end else if (span == 16'd0) begin
      r.code  = FAULT_SPAN_ZERO;
      r.angle = '0;
    end else begin
      // quotient truncates toward zero, angle kept wide for the checks
      angle = longint'(low_cdeg) + ((longint'(raw) - longint'(low_raw)) *
              (longint'(high_cdeg) - longint'(low_cdeg))) / longint'(span);
      mag   = (angle < 0) ? -angle : angle;
      jump  = angle - longint'(last_good);
      if (jump < 0) jump = -jump;
      if (mag > longint'(abs_lim)) begin
        r.code = FAULT_IMPLAUSIBLE;
      end else if (jump_lim != 16'd0 && have_good && jump > longint'(jump_lim)) begin
        r.code = FAULT_IMPLAUSIBLE;
      end else begin
        last_good = 16'(angle);
        have_good = 1'b1;
        r.valid   = 1'b1;
        r.angle   = 16'(angle);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : mon
    reading_t want;
    if (!rst_n) begin
      low_raw   = 16'd0;
      high_raw  = 16'd65535;
      low_cdeg  = -16'sd4000;
      high_cdeg = 16'sd4000;
      vref      = 13'd3300;
      abs_lim   = 15'd4000;
      jump_lim  = 16'd500;
      present   = 1'b0;
      last_good = '0;
      have_good = 1'b0;
      last_read = '0;
      expected_readings.delete();
    end else begin
      // result side first, so an item taken in the same cycle queues behind
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result item with nothing expected, tdata %0h tuser %0h",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_readings.pop_front();
          check_field("angle_valid", 64'(want.valid), 64'(out_tuser[0]));
          check_field("fresh_flag", 64'(want.fresh), 64'(out_tuser[1]));
          check_field("fault_code", 64'(want.code), 64'(out_tuser[4:2]));
          check_field("angle_cdeg", 64'(want.angle), 64'(out_tdata[15:0]));
          check_field("raw_echo", 64'(want.raw), 64'(out_tdata[31:16]));
          check_field("voltage_mv", 64'(want.mv), 64'(out_tdata[44:32]));
          check_field("sample_time_us", want.ts, out_tdata[108:45]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CAL_LOW_RAW:     low_raw   = cfg_data;
          REG_CAL_HIGH_RAW:    high_raw  = cfg_data;
          REG_CAL_LOW_CDEG:    low_cdeg  = cfg_data;
          REG_CAL_HIGH_CDEG:   high_cdeg = cfg_data;
          REG_VREF_MV:         vref      = cfg_data[12:0];
          REG_ABS_LIMIT_CDEG:  abs_lim   = cfg_data[14:0];
          REG_JUMP_LIMIT_CDEG: jump_lim  = cfg_data;
          REG_ADC_PRESENT:     present   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(predict_reading(in_tdata[63:0], in_tdata[79:64]));
      end
    end
    pending    <= expected_readings.size();
    fail_count <= errs;
  end

endmodule

@@ bench/tb.sv @@
module tb;
  import wac_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [63:0] sample_ts, [79:64] raw_sample
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // [15:0] angle_cdeg, [31:16] raw_echo, [44:32] voltage_mv, [108:45] sample_time_us
  logic [OUT_DATA_W-1:0] out_tdata;
  // [0] angle_valid, [1] fresh_flag, [4:2] fault_code
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int snd_idle_pct = 19;
  int rcv_idle_pct = 55;
  int hold_left    = 0;
  int stall_cnt    = 0;

  wheel_angle_calibrate_check_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wheel_angle_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold when one is requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one sample; each cycle in front idles with the sender's idle odds
  task automatic send_sample(input logic [63:0] ts, input logic [15:0] raw);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {raw, ts};
    do @(posedge clk); while (!in_tready);
  endtask

  // Register write; valid stays up between back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [15:0] lo, hi, cur, lc, hc, abs_v, jump_v, vref_v;
    logic [63:0] now_us, ts;
    logic [15:0] raw;
    int          stp, nxt, r;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CAL_LOW_RAW;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // converter absent out of reset: nothing read yet
    send_sample(64'd123, 16'd500);
    send_sample('1, '1);
    settle();

    // reset calibration, converter bound
    write_reg(REG_ADC_PRESENT, 16'd1, 1'b1);
    send_sample(64'd0, 16'd0);
    send_sample(64'd1, 16'd65535);          // jump too large
    send_sample(64'd2, 16'd100);
    send_sample(64'h8000_0000_0000_0000, 16'd32768);
    settle();
    write_reg(REG_JUMP_LIMIT_CDEG, 16'd0, 1'b1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 16'd65535);
    send_sample(64'd5, 16'd32767);
    settle();

    // zero span, and a zero reading with a nonzero lower point
    write_reg(REG_CAL_LOW_RAW, 16'd1000, 1'b0);
    write_reg(REG_CAL_HIGH_RAW, 16'd1000, 1'b1);
    send_sample(64'd10, 16'd0);
    send_sample(64'd11, 16'd1);
    send_sample(64'd12, 16'd65535);
    settle();

    // wrapped span, widest angles, widest limits
    write_reg(REG_CAL_LOW_RAW, 16'd60000, 1'b0);
    write_reg(REG_CAL_HIGH_RAW, 16'd4000, 1'b0);
    write_reg(REG_CAL_LOW_CDEG, -16'sd18000, 1'b0);
    write_reg(REG_CAL_HIGH_CDEG, 16'sd18000, 1'b0);
    write_reg(REG_VREF_MV, 16'd5000, 1'b0);
    write_reg(REG_ABS_LIMIT_CDEG, 16'd18000, 1'b0);
    write_reg(REG_JUMP_LIMIT_CDEG, 16'd36000, 1'b1);
    send_sample(64'd20, 16'd60000);
    send_sample(64'd21, 16'd4000);
    send_sample(64'd22, 16'd0);
    send_sample(64'd23, 16'd1000);          // far below the lower point
    send_sample(64'd24, 16'd65535);
    settle();

    // full-width register values, tight limits
    write_reg(REG_CAL_LOW_RAW, 16'd0, 1'b0);
    write_reg(REG_CAL_LOW_CDEG, 16'h8000, 1'b0);
    write_reg(REG_CAL_HIGH_CDEG, 16'h7FFF, 1'b0);
    write_reg(REG_VREF_MV, 16'h1FFF, 1'b0);
    write_reg(REG_ABS_LIMIT_CDEG, 16'h7FFF, 1'b0);
    write_reg(REG_JUMP_LIMIT_CDEG, 16'd1, 1'b1);
    send_sample(64'd30, 16'd0);
    send_sample(64'd31, 16'd2000);
    settle();
    write_reg(REG_ABS_LIMIT_CDEG, 16'd0, 1'b0);
    write_reg(REG_VREF_MV, 16'd1, 1'b0);
    write_reg(REG_ADC_PRESENT, 16'd0, 1'b1);
    send_sample(64'd40, 16'd3000);          // absent: last read time held
    settle();

    // random settings, each with a run of samples walking around the calibrated range
    now_us = 64'd1000;
    for (int ph = 0; ph < 12; ph++) begin
      lo = ($urandom_range(99) < 20) ? 16'd0 : 16'($urandom);
      r  = $urandom_range(99);
      hi = (r < 10) ? lo : (r < 20) ? 16'd65535 : 16'($urandom);
      lc = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 36000) - 18000);
      hc = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 36000) - 18000);
      vref_v = ($urandom_range(99) < 10) ? 16'($urandom_range(0, 8191))
                                         : 16'($urandom_range(1, 5000));
      r  = $urandom_range(99);
      abs_v = (r < 60) ? 16'd18000 : (r < 70) ? 16'($urandom_range(0, 32767))
                                              : 16'($urandom_range(0, 18000));
      r  = $urandom_range(99);
      jump_v = (r < 15) ? 16'd0 : (r < 25) ? 16'($urandom) : 16'($urandom_range(1, 36000));
      write_reg(REG_CAL_LOW_RAW, lo, 1'b0);
      write_reg(REG_CAL_HIGH_RAW, hi, 1'b0);
      write_reg(REG_CAL_LOW_CDEG, lc, 1'b0);
      write_reg(REG_CAL_HIGH_CDEG, hc, 1'b0);
      write_reg(REG_VREF_MV, vref_v, 1'b0);
      write_reg(REG_ABS_LIMIT_CDEG, abs_v, 1'b0);
      write_reg(REG_JUMP_LIMIT_CDEG, jump_v, 1'b0);
      write_reg(REG_ADC_PRESENT, ($urandom_range(99) < 90) ? 16'd1 : 16'd0, 1'b1);

      // idling pattern: sender light / receiver heavy, then swapped, then none
      if (ph < 4) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 55;
      end else if (ph < 8) begin
        snd_idle_pct = 55;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long receiver hold so the block backs up onto its input
      if (ph == 5) hold_left = 300;

      stp = $urandom_range(1, 3000);
      cur = lo + ((hi - lo) >> 1);
      repeat (156) begin
        r = $urandom_range(99);
        if (r < 70) begin
          nxt = int'(cur) + $urandom_range(0, 2 * stp) - stp;
          raw = (nxt < 0) ? 16'd0 : (nxt > 65535) ? 16'd65535 : 16'(nxt);
        end else if (r < 78) begin
          raw = 16'd0;
        end else if (r < 86) begin
          raw = (($urandom_range(1) == 1) ? hi : lo) + 16'($urandom_range(0, 2)) - 16'd1;
        end else begin
          raw = 16'($urandom);
        end
        cur = raw;
        if ($urandom_range(99) < 10) begin
          ts = {$urandom, $urandom};
        end else begin
          now_us = now_us + 64'($urandom_range(1, 20000));
          ts = now_us;
        end
        send_sample(ts, raw);
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ wheel_angle_calibrate_check_top.f @@
+incdir+src
src/wac_pkg.sv
src/wac_div.sv
src/wac_ctrl.sv
src/wac_dp.sv
src/wheel_angle_calibrate_check_top.sv
bench/wheel_angle_checker.sv
bench/tb.sv
